// ----- rtl/vtx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex transform shared definitions
// Types, widths and constants used by the Q16.16 matrix-vector pipeline.
// ----------------------------------------------------------------------------
package vtx_pkg;

  localparam int Dim       = 4;
  localparam int CompW     = 32;
  localparam int FracBits  = 16;
  localparam int NumRegs   = 8;
  localparam int CfgIdxW   = $clog2(NumRegs);
  localparam int CfgDataW  = 2 * CompW;
  localparam int ProdW     = 2 * CompW;
  localparam int PairW     = ProdW + 1;
  localparam int AccW      = ProdW + 2;
  localparam int VecW      = Dim * CompW;

  typedef logic signed [CompW-1:0]  q16_t;
  typedef q16_t        [Dim-1:0]    vec_t;
  typedef vec_t        [Dim-1:0]    mat_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef prod_t       [Dim-1:0]    prod_row_t;
  typedef prod_row_t   [Dim-1:0]    prod_mat_t;
  typedef logic signed [PairW-1:0]  pair_t;
  typedef pair_t       [1:0]        pair_row_t;
  typedef pair_row_t   [Dim-1:0]    pair_mat_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef acc_t        [Dim-1:0]    acc_vec_t;
  typedef logic        [CfgDataW-1:0] cfg_word_t;
  typedef cfg_word_t   [NumRegs-1:0]  cfg_file_t;

  typedef struct packed {
    vec_t comp;
    logic sat;
  } result_t;

  localparam acc_t HalfLsb = acc_t'(1) << (FracBits - 1);
  localparam q16_t Q16Max  = {1'b0, {(CompW-1){1'b1}}};
  localparam q16_t Q16Min  = {1'b1, {(CompW-1){1'b0}}};

  localparam cfg_word_t OneLow  = cfg_word_t'(1) << FracBits;
  localparam cfg_word_t OneHigh = cfg_word_t'(1) << (FracBits + CompW);
  localparam cfg_word_t Zero    = '0;

  // Identity matrix after reset.
  localparam cfg_file_t CfgReset = '{OneHigh, Zero, OneLow, Zero,
                                     Zero, OneHigh, Zero, OneLow};

endpackage : vtx_pkg
`default_nettype wire

// ----- rtl/vertex_transform_4x4.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex transform 4x4
// Multiplies a Q16.16 homogeneous vector by a configurable 4x4 matrix.
// ----------------------------------------------------------------------------
// Throughput: one vector per cycle unless the output stalls; four register
// stages (products, pair sums, row totals, rounding and clamping) each with
// its own valid bit. A stalled output holds its result while earlier stages
// keep filling. Reset clears all valid bits and loads the identity matrix.
module vertex_transform_4x4 (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [vtx_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [vtx_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: x_in, y_in, z_in, w_in.
  input  wire logic [vtx_pkg::VecW-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // Fields from bit 0: x_out, y_out, z_out, w_out.
  output logic [vtx_pkg::VecW-1:0]         m_axis_tdata,
  // Fields from bit 0: saturated.
  output logic                             m_axis_tuser
);
  import vtx_pkg::*;

  mat_t      coef;
  prod_mat_t prod;
  acc_vec_t  acc;
  result_t   res;
  logic      mul_valid, mul_ready;
  logic      sum_valid, sum_ready;

  vtx_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_word_t'(cfg_wdata_i)),
    .coef_o      (coef)
  );

  vtx_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .vec_i       (vec_t'(s_axis_tdata)),
    .coef_i      (coef),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .prod_o      (prod)
  );

  vtx_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .prod_i      (prod),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .acc_o       (acc)
  );

  vtx_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .acc_i       (acc),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res.comp;
  assign m_axis_tuser = res.sat;

endmodule : vertex_transform_4x4
`default_nettype wire

// ----- rtl/vtx_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Coefficient register file
// Eight 64-bit registers, each holding two Q16.16 coefficients of a row.
// ----------------------------------------------------------------------------
module vtx_cfg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [vtx_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire vtx_pkg::cfg_word_t       cfg_wdata_i,
  output vtx_pkg::mat_t                 coef_o
);
  import vtx_pkg::*;

  cfg_file_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CfgReset;
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  for (genvar r = 0; r < Dim; r++) begin : g_row
    for (genvar c = 0; c < Dim; c++) begin : g_col
      localparam int RegSel = r * 2 + c / 2;
      localparam int Lsb    = (c % 2) * CompW;
      assign coef_o[r][c] = regs_q[RegSel][Lsb +: CompW];
    end
  end

endmodule : vtx_cfg
`default_nettype wire

// ----- rtl/vtx_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Product stage
// Sixteen 32x32 signed multipliers with registered full-width products.
// ----------------------------------------------------------------------------
module vtx_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vtx_pkg::vec_t      vec_i,
  input  wire vtx_pkg::mat_t      coef_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output vtx_pkg::prod_mat_t      prod_o
);
  import vtx_pkg::*;

  logic      valid_q;
  logic      en;
  prod_mat_t prod_d, prod_q;

  assign en = !valid_q || out_ready_i;

  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      for (int c = 0; c < Dim; c++) begin
        prod_d[r][c] = $signed(coef_i[r][c]) * $signed(vec_i[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = valid_q;
  assign prod_o      = prod_q;

endmodule : vtx_mul
`default_nettype wire

// ----- rtl/vtx_sum.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Row adder tree
// Two registered levels: pair sums, then the row total plus half an LSB.
// ----------------------------------------------------------------------------
module vtx_sum (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vtx_pkg::prod_mat_t prod_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output vtx_pkg::acc_vec_t       acc_o
);
  import vtx_pkg::*;

  logic      pair_valid_q, acc_valid_q;
  logic      pair_en, acc_en;
  pair_mat_t pair_d, pair_q;
  acc_vec_t  acc_d, acc_q;

  assign acc_en  = !acc_valid_q || out_ready_i;
  assign pair_en = !pair_valid_q || acc_en;

  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      for (int k = 0; k < 2; k++) begin
        pair_d[r][k] = pair_t'(prod_i[r][2*k]) + pair_t'(prod_i[r][2*k+1]);
      end
      acc_d[r] = acc_t'(pair_q[r][0]) + acc_t'(pair_q[r][1]) + HalfLsb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      acc_valid_q  <= 1'b0;
    end else begin
      if (pair_en) begin
        pair_valid_q <= in_valid_i;
      end
      if (acc_en) begin
        acc_valid_q <= pair_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_en && in_valid_i) begin
      pair_q <= pair_d;
    end
    if (acc_en && pair_valid_q) begin
      acc_q <= acc_d;
    end
  end

  assign in_ready_o  = pair_en;
  assign out_valid_o = acc_valid_q;
  assign acc_o       = acc_q;

endmodule : vtx_sum
`default_nettype wire

// ----- rtl/vtx_sat.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rounding and saturation stage
// Drops the fraction of each rounded row sum and clamps it to 32 bits.
// ----------------------------------------------------------------------------
module vtx_sat (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vtx_pkg::acc_vec_t  acc_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output vtx_pkg::result_t        res_o
);
  import vtx_pkg::*;

  localparam int TopLsb = FracBits + CompW - 1;

  logic    valid_q;
  logic    en;
  logic    [Dim-1:0] clip;
  result_t res_d, res_q;

  assign en = !valid_q || out_ready_i;

  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      clip[r] = !((&acc_i[r][AccW-1:TopLsb]) || !(|acc_i[r][AccW-1:TopLsb]));
      if (!clip[r]) begin
        res_d.comp[r] = acc_i[r][FracBits +: CompW];
      end else if (acc_i[r][AccW-1]) begin
        res_d.comp[r] = Q16Min;
      end else begin
        res_d.comp[r] = Q16Max;
      end
    end
    res_d.sat = |clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule : vtx_sat
`default_nettype wire
